// ===== rtl/i2c_rtm_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C register transaction master - shared definitions
// Item and result records, command codes and the bus segment type.
// ----------------------------------------------------------------------------
`default_nettype none

package i2c_rtm_pkg;

	localparam int unsigned MAX_READ_LEN_DEF = 64;

	// request kinds
	localparam logic KIND_CMD  = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// transaction operations
	localparam logic [1:0] OP_PROBE   = 2'd0;
	localparam logic [1:0] OP_WRITE8  = 2'd1;
	localparam logic [1:0] OP_WRITE16 = 2'd2;
	localparam logic [1:0] OP_READ    = 2'd3;

	typedef enum logic [3:0] {
		SEG_IDLE   = 4'd0,
		SEG_START  = 4'd1,
		SEG_WADDR  = 4'd2,
		SEG_WREG   = 4'd3,
		SEG_WLO    = 4'd4,
		SEG_WHI    = 4'd5,
		SEG_RSTART = 4'd6,
		SEG_RADDR  = 4'd7,
		SEG_RDATA  = 4'd8,
		SEG_STOP   = 4'd9
	} seg_t;

	typedef struct packed {
		logic        kind;
		logic [6:0]  dev_addr;
		logic [1:0]  op;
		logic [7:0]  reg_addr;
		logic [15:0] wr_data;
		logic [6:0]  rd_len;
		logic        sda_in;
	} item_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       byte_valid;
		logic [7:0] rd_byte;
		logic [5:0] byte_index;
		logic       done_res;
		logic       ack_ok;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/i2c_register_transaction_master.sv =====
// ----------------------------------------------------------------------------
// I2C register transaction master - top level
// Input register, bus sequencer and output register with stream handshakes.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes requests: s_tuser = 0 is a command that starts
//   a probe, register write (8 or 16 bit) or register read; s_tuser = 1 is a
//   tick that advances the bus by one bus slot and carries the SDA
//   level seen in that slot. A command arriving mid-transaction is dropped.
//   The master channel gives one result per tick: SCL/SDA levels of the slot,
//   any received read byte, and on the final stop slot m_tlast with ack_ok.
//   Commands give no result.
// Timing:
//   A request is held in the input register and is then applied to the
//   sequencer, which also loads the output register, so a result is
//   offered from the output register once its tick has left the input
//   register. One request per cycle is taken, limited only by the output
//   register draining.
// Stall and reset:
//   While the result waits, a following command still advances; a following
//   tick waits in the input register and s_tready drops until the result is
//   taken. Reset empties both registers and returns the bus to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_register_transaction_master #(
	parameter int unsigned MAX_READ_LEN = i2c_rtm_pkg::MAX_READ_LEN_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	// dev_addr[6:0], op[8:7], reg_addr[16:9], wr_data[32:17], rd_len[39:33],
	// sda_in[40], zero fill [47:41]
	input  wire  [47:0] s_tdata,
	// kind
	input  wire         s_tuser,
	output logic        m_tvalid,
	input  wire         m_tready,
	// scl_level[0], sda_level[1], byte_valid[2], rd_byte[10:3],
	// byte_index[16:11], ack_ok[17], zero fill [23:18]
	output logic [23:0] m_tdata,
	// done_res
	output logic        m_tlast
);
	import i2c_rtm_pkg::*;

	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t res_q;
	logic    res_valid_q;
	logic    advance;

	// a command never produces a result, so it may pass a stalled output
	assign advance  = valid_s1 && (item_s1.kind == KIND_CMD || !res_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.kind     <= s_tuser;
			item_s1.dev_addr <= s_tdata[6:0];
			item_s1.op       <= s_tdata[8:7];
			item_s1.reg_addr <= s_tdata[16:9];
			item_s1.wr_data  <= s_tdata[32:17];
			item_s1.rd_len   <= s_tdata[39:33];
			item_s1.sda_in   <= s_tdata[40];
		end
	end

	i2c_rtm_seq #(
		.MAX_READ_LEN(MAX_READ_LEN)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.res    (res)
	);

	// hold the result until taken; load a fresh one for every tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && item_s1.kind == KIND_TICK) begin
			res_valid_q <= 1'b1;
		end else if (m_tready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.kind == KIND_TICK) begin
			res_q <= res;
		end
	end

	assign m_tvalid = res_valid_q;
	assign m_tlast  = res_q.done_res;
	assign m_tdata  = {6'd0, res_q.ack_ok, res_q.byte_index, res_q.rd_byte,
		res_q.byte_valid, res_q.sda_level, res_q.scl_level};

	a_ack_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> !m_tdata[17])
		else $error("ack flag outside the final slot");

	a_byte_scl_high: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[2]) |-> m_tdata[0])
		else $error("read byte completed outside an SCL-high slot");

	a_done_released: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tdata[0] && m_tdata[1]))
		else $error("final slot without both lines released");

endmodule

`default_nettype wire

// ===== rtl/i2c_rtm_seq.sv =====
// ----------------------------------------------------------------------------
// I2C register transaction master - bus sequencer
// Holds the transaction state and advances it by one bus slot per tick.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_rtm_seq #(
	parameter int unsigned MAX_READ_LEN = i2c_rtm_pkg::MAX_READ_LEN_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   step,
	input  i2c_rtm_pkg::item_t    item,
	output i2c_rtm_pkg::result_t  res
);
	import i2c_rtm_pkg::*;

	localparam int unsigned LenClamp = (MAX_READ_LEN > 127) ? 127 : MAX_READ_LEN;

	seg_t        phase_q, phase_n;
	logic [4:0]  slot_q, slot_n;
	logic [1:0]  sub_q, sub_n;
	logic [7:0]  shift_q, shift_n;
	logic [6:0]  done_cnt_q, done_cnt_n;
	logic        ack_q, ack_n;
	logic [6:0]  addr_q;
	logic [1:0]  op_q;
	logic [7:0]  reg_q;
	logic [15:0] data_q;
	logic [6:0]  len_q;

	logic [6:0]  eff_len;
	logic [6:0]  done_inc;
	logic        last;
	logic        tick;
	logic [7:0]  rd_shift;

	assign eff_len  = (len_q > 7'(LenClamp)) ? 7'(LenClamp) : len_q;
	assign done_inc = done_cnt_q + 7'd1;
	assign tick     = step && (item.kind == KIND_TICK);
	assign rd_shift = {shift_q[6:0], item.sda_in};

	always_comb begin
		res        = '0;
		res.scl_level = 1'b1;
		res.sda_level = 1'b1;
		last       = 1'b0;
		phase_n    = phase_q;
		slot_n     = slot_q;
		sub_n      = sub_q;
		shift_n    = shift_q;
		done_cnt_n = done_cnt_q;
		ack_n      = ack_q;

		case (phase_q)
			SEG_START, SEG_RSTART: begin
				res.scl_level = (slot_q < 5'd2);
				res.sda_level = (slot_q == 5'd0);
				last = (slot_q >= 5'd2);
			end
			SEG_WADDR, SEG_WREG, SEG_WLO, SEG_WHI, SEG_RADDR: begin
				if (slot_q < 5'd24) begin
					res.sda_level = shift_q[7];
					res.scl_level = (sub_q == 2'd1);
					if (sub_q == 2'd2) shift_n = {shift_q[6:0], 1'b0};
				end else begin
					res.scl_level = (slot_q == 5'd25);
					if (slot_q == 5'd25 && item.sda_in) ack_n = 1'b0;
					last = (slot_q >= 5'd26);
				end
			end
			SEG_RDATA: begin
				if (slot_q < 5'd16) begin
					if (!slot_q[0]) begin
						shift_n = rd_shift;
						if (slot_q == 5'd14) begin
							res.byte_valid = 1'b1;
							res.rd_byte    = rd_shift;
							res.byte_index = done_cnt_q[5:0];
						end
					end else begin
						res.scl_level = 1'b0;
					end
				end else if (slot_q < 5'd19) begin
					res.scl_level = (slot_q == 5'd17);
					res.sda_level = !({1'b0, done_cnt_q} + 8'd1 < {1'b0, eff_len});
				end else begin
					res.scl_level = 1'b0;
					last = 1'b1;
				end
			end
			SEG_STOP: begin
				res.scl_level = (slot_q != 5'd0);
				res.sda_level = (slot_q >= 5'd2);
				if (slot_q >= 5'd2) begin
					res.done_res = 1'b1;
					res.ack_ok   = ack_q;
					last = 1'b1;
				end
			end
			default: begin
			end
		endcase

		if (phase_q != SEG_IDLE) begin
			if (last) begin
				slot_n = 5'd0;
				sub_n  = 2'd0;
				case (phase_q)
					SEG_START: begin
						phase_n = SEG_WADDR;
						shift_n = {addr_q, 1'b0};
					end
					SEG_WADDR: begin
						if (op_q == OP_PROBE) begin
							phase_n = SEG_STOP;
						end else begin
							phase_n = SEG_WREG;
							shift_n = reg_q;
						end
					end
					SEG_WREG: begin
						if (op_q == OP_READ) begin
							phase_n = SEG_RSTART;
						end else begin
							phase_n = SEG_WLO;
							shift_n = data_q[7:0];
						end
					end
					SEG_WLO: begin
						if (op_q == OP_WRITE16) begin
							phase_n = SEG_WHI;
							shift_n = data_q[15:8];
						end else begin
							phase_n = SEG_STOP;
						end
					end
					SEG_WHI:    phase_n = SEG_STOP;
					SEG_RSTART: begin
						phase_n = SEG_RADDR;
						shift_n = {addr_q, 1'b1};
					end
					SEG_RADDR: begin
						if (ack_q && eff_len != 7'd0) begin
							phase_n = SEG_RDATA;
							shift_n = 8'h00;
						end else begin
							phase_n = SEG_STOP;
						end
					end
					SEG_RDATA: begin
						done_cnt_n = done_inc;
						if (done_inc < eff_len) begin
							phase_n = SEG_RDATA;
							shift_n = 8'h00;
						end else begin
							phase_n = SEG_STOP;
						end
					end
					default: phase_n = SEG_IDLE;
				endcase
			end else begin
				slot_n = slot_q + 5'd1;
				sub_n  = (sub_q == 2'd2) ? 2'd0 : sub_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= SEG_IDLE;
			slot_q     <= '0;
			sub_q      <= '0;
			shift_q    <= '0;
			done_cnt_q <= '0;
			ack_q      <= 1'b1;
			addr_q     <= '0;
			op_q       <= OP_PROBE;
			reg_q      <= '0;
			data_q     <= '0;
			len_q      <= 7'd1;
		end else if (step) begin
			if (item.kind == KIND_CMD) begin
				// drop a command while a transaction is running
				if (phase_q == SEG_IDLE) begin
					addr_q     <= item.dev_addr;
					op_q       <= item.op;
					reg_q      <= item.reg_addr;
					data_q     <= item.wr_data;
					len_q      <= item.rd_len;
					ack_q      <= 1'b1;
					done_cnt_q <= '0;
					phase_q    <= SEG_START;
					slot_q     <= '0;
					sub_q      <= '0;
				end
			end else begin
				phase_q    <= phase_n;
				slot_q     <= slot_n;
				sub_q      <= sub_n;
				shift_q    <= shift_n;
				done_cnt_q <= done_cnt_n;
				ack_q      <= ack_n;
			end
		end
	end

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= 5'd26)
		else $error("slot counter beyond the longest segment");

	a_idle_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == SEG_IDLE) |-> (slot_q == 5'd0))
		else $error("slot counter running while idle");

	a_sub_range: assert property (@(posedge clk) disable iff (!arst_n)
		sub_q != 2'd3)
		else $error("bit phase counter out of range");

	a_stop_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(tick && res.done_res) |=> (phase_q == SEG_IDLE))
		else $error("sequencer not idle after stop");

endmodule

`default_nettype wire
